@@ hdl/readout_packet_framer_assert.svh @@
// Assertion macros shared by the framer modules.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef READOUT_PACKET_FRAMER_ASSERT_SVH
`define READOUT_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rpf_pkg.sv @@
package rpf_pkg;

    // Framer modes
    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_A    = 2'd1;
    localparam logic [1:0] MODE_B    = 2'd2;

    // Header and trailer codes
    localparam logic [15:0] WORD_8000 = 16'h8000;
    localparam logic [15:0] WORD_0001 = 16'h0001;
    localparam logic [15:0] WORD_FFFF = 16'hFFFF;
    localparam logic [3:0]  NIB_9     = 4'h9;
    localparam logic [3:0]  NIB_A     = 4'hA;
    localparam logic [3:0]  NIB_E     = 4'hE;
    localparam logic [3:0]  NIB_F     = 4'hF;

    // Packet position and tail countdown
    localparam logic [4:0] POS_HEAD_LAST = 5'd7;
    localparam logic [4:0] POS_TAIL_MIN  = 5'd11;
    localparam logic [4:0] POS_MAX       = 5'd31;
    localparam logic [3:0] TAIL_LEN      = 4'd8;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] IDX_FIRST = 3'd0;
    localparam logic [2:0] IDX_LAST  = 3'd7;

    typedef struct packed {
        logic [15:0] data_word;
        logic        end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [15:0] packet_word;
        logic        packet_kind;
        logic        first_word;
        logic        last_word;
        logic        truncated;
    } t_out_beat;

    // One classified item: a full 8-word head or a single packet word in slot 7
    typedef struct packed {
        logic [7:0][15:0] words;
        logic             burst;
        logic             kind;
        logic             close;
        logic             trunc;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    // Build the output beat for slot idx of a command
    function automatic t_out_beat make_beat(input t_cmd cmd, input logic [2:0] idx);
        t_out_beat b;
        b.packet_word = cmd.words[idx];
        b.packet_kind = cmd.kind;
        b.first_word  = cmd.burst && (idx == IDX_FIRST);
        b.last_word   = cmd.close && (idx == IDX_LAST);
        b.truncated   = cmd.trunc && (idx == IDX_LAST);
        return b;
    endfunction

endpackage

@@ hdl/readout_packet_framer.sv @@
// Readout packet framer.
// Input channel: i_in_valid / o_in_stall carry one i_in_item beat (data word plus
// end-of-stream flag) per cycle. Output channel: o_out_valid / i_out_stall carry
// one o_out_beat per framed packet word with kind, first, last and truncated flags.
// A beat moves on an edge where valid is high and stall is low.
// The front classifies each word against an 8-word window and queues a command;
// a 4-entry queue decouples it from the back, which expands commands into beats.
// An accepted word is written into the queue, then loaded into the output
// register, from which the receiver takes it.
// Throughput: one word per cycle inside a packet while the receiver does not stall.
// A packet start emits the 8 head words one after another; words arriving meanwhile
// fill the queue, and o_in_stall rises only when the queue holds 4 commands.
// Words outside a packet are dropped without using the queue.
// Reset (synchronous, active low) clears the window, mode, position, tail
// countdown, queue and output valid flag; the block then hunts for a header.
// When the receiver stalls, the output beat holds; the back stops pulling from
// the queue, and the input stalls once the queue is full.
module readout_packet_framer
    import rpf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_push push;
    logic  q_full, q_valid, q_pop;
    t_cmd  q_head;

    rpf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push)
    );

    rpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    rpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

@@ hdl/rpf_front.sv @@
module rpf_front
    import rpf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_in_stall,
    output t_push    o_push
);

    logic [7:0][15:0] r_win, n_win;
    logic [1:0]       r_mode, n_mode;
    logic [4:0]       r_pos, n_pos;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_armed, n_armed;

    logic [7:0][15:0] shifted;
    logic             accept, hunting, start_a, start_b, marker_a, trailer_b, done, eos;
    logic [4:0]       pos_inc;
    logic [3:0]       cnt_dec;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign eos        = i_in_item.end_of_stream;
    assign shifted    = {i_in_item.data_word, r_win[7:1]};
    assign hunting    = (r_mode != MODE_A) && (r_mode != MODE_B);
    assign pos_inc    = (r_pos != POS_MAX) ? r_pos + 5'd1 : r_pos;
    assign cnt_dec    = r_cnt - 4'd1;

    // Classify the shifted window
    always_comb begin
        start_a  = (shifted[5] == WORD_8000) && (shifted[6] == WORD_0001)
                && (shifted[7] == WORD_8000);
        marker_a = (shifted[4] == WORD_8000) && (shifted[5] == WORD_8000)
                && (shifted[6] == WORD_FFFF) && (shifted[7] == WORD_8000);
        start_b   = 1'b1;
        trailer_b = 1'b1;
        for (int i = 0; i < 4; i++) begin
            start_b   = start_b && (shifted[i][15:12] == NIB_9);
            trailer_b = trailer_b && (shifted[i][15:12] == NIB_F);
        end
        for (int i = 4; i < 7; i++) begin
            start_b   = start_b && (shifted[i][15:12] == NIB_A);
            trailer_b = trailer_b && (shifted[i][15:12] == NIB_E);
        end
    end

    // End of packet for the current word
    always_comb begin
        done = 1'b0;
        if (r_mode == MODE_A) begin
            done = r_armed && (cnt_dec == 4'd0);
        end else if (r_mode == MODE_B) begin
            done = trailer_b;
        end
    end

    // Next state and queue command
    always_comb begin
        n_win   = r_win;
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_armed = r_armed;
        o_push.push       = 1'b0;
        o_push.cmd.words  = shifted;
        o_push.cmd.burst  = hunting;
        o_push.cmd.kind   = hunting ? !start_a : (r_mode == MODE_B);
        o_push.cmd.close  = hunting ? eos : (done || eos);
        o_push.cmd.trunc  = hunting ? eos : (eos && !done);
        if (accept) begin
            if (hunting) begin
                o_push.push = start_a || start_b;
                if (eos) begin
                    n_win   = '0;
                    n_mode  = MODE_HUNT;
                    n_pos   = '0;
                    n_cnt   = '0;
                    n_armed = 1'b0;
                end else begin
                    n_win = shifted;
                    if (start_a || start_b) begin
                        n_mode  = start_a ? MODE_A : MODE_B;
                        n_pos   = POS_HEAD_LAST;
                        n_cnt   = '0;
                        n_armed = 1'b0;
                    end
                end
            end else begin
                o_push.push = 1'b1;
                if (done || eos) begin
                    n_win   = '0;
                    n_mode  = MODE_HUNT;
                    n_pos   = '0;
                    n_cnt   = '0;
                    n_armed = 1'b0;
                end else begin
                    n_win = shifted;
                    n_pos = pos_inc;
                    if (r_mode == MODE_A) begin
                        if (r_armed) begin
                            n_cnt = cnt_dec;
                        end else if ((pos_inc >= POS_TAIL_MIN) && marker_a) begin
                            n_armed = 1'b1;
                            n_cnt   = TAIL_LEN;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_mode  <= MODE_HUNT;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_armed <= 1'b0;
        end else begin
            r_win   <= n_win;
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_armed <= n_armed;
        end
    end

endmodule

@@ hdl/rpf_queue.sv @@
`include "readout_packet_framer_assert.svh"

module rpf_queue
    import rpf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_cmd  o_head
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (i_push.push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    `RPF_ASSERT_NOW(a_no_overflow, i_push.push, !o_full, "push into full queue")
    `RPF_ASSERT_NOW(a_no_underflow, i_pop, o_valid, "pop from empty queue")
    `RPF_ASSERT_NEXT(a_count_track, i_push.push && !i_pop, r_count == $past(r_count) + QCNT_W'(1),
        "queue count did not advance on push")

endmodule

@@ hdl/rpf_back.sv @@
`include "readout_packet_framer_assert.svh"

module rpf_back
    import rpf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_head,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_beat
);

    t_cmd      r_cur;
    logic [2:0] r_idx;
    logic      r_busy;
    logic      r_out_valid;
    t_out_beat r_out_beat;
    logic      load_ok;

    assign load_ok     = !r_out_valid || !i_out_stall;
    assign o_pop       = load_ok && !r_busy && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // Hold the current head and step through its words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= IDX_FIRST;
            r_out_valid <= 1'b0;
        end else if (load_ok) begin
            if (r_busy) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 3'd1;
                r_busy      <= (r_idx != IDX_LAST);
            end else if (i_q_valid) begin
                r_out_valid <= 1'b1;
                r_busy      <= i_q_head.burst;
                r_idx       <= IDX_FIRST + 3'd1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            if (r_busy) begin
                r_out_beat <= make_beat(r_cur, r_idx);
            end else if (i_q_valid) begin
                r_cur      <= i_q_head;
                r_out_beat <= make_beat(i_q_head, i_q_head.burst ? IDX_FIRST : IDX_LAST);
            end
        end
    end

    `RPF_ASSERT_NOW(a_busy_idx, r_busy, r_idx != IDX_FIRST, "burst index wrapped while busy")
    `RPF_ASSERT_NOW(a_trunc_last, r_out_valid && r_out_beat.truncated, r_out_beat.last_word,
        "truncated beat not marked last")
    `RPF_ASSERT_NOW(a_first_not_trunc, r_out_valid && r_out_beat.first_word,
        !r_out_beat.truncated, "first beat marked truncated")

endmodule
